@@ src/gcs_pkg.sv @@
// Shared types, class codes and helper functions for the grapheme cluster segmenter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gcs_pkg;

    localparam int unsigned MaxTextLen = 65535;
    localparam int unsigned QDepth     = 4;
    localparam int unsigned QPtrW      = $clog2(QDepth);

    localparam logic [16:0] ColMax = 17'd131070;

    // line break classes
    localparam logic [5:0] LB_BK = 6'd0;
    localparam logic [5:0] LB_NL = 6'd1;
    localparam logic [5:0] LB_SP = 6'd2;
    localparam logic [5:0] LB_ZW = 6'd3;
    localparam logic [5:0] LB_WJ = 6'd4;
    localparam logic [5:0] LB_SA = 6'd5;
    localparam logic [5:0] LB_CM = 6'd6;
    localparam logic [5:0] LB_AL = 6'd7;

    // grapheme break classes
    localparam logic [3:0] GB_CR     = 4'd1;
    localparam logic [3:0] GB_LF     = 4'd2;
    localparam logic [3:0] GB_CTRL   = 4'd3;
    localparam logic [3:0] GB_EXT    = 4'd4;
    localparam logic [3:0] GB_SPMARK = 4'd5;
    localparam logic [3:0] GB_PRE    = 4'd6;
    localparam logic [3:0] GB_L      = 4'd7;
    localparam logic [3:0] GB_V      = 4'd8;
    localparam logic [3:0] GB_T      = 4'd9;
    localparam logic [3:0] GB_LV     = 4'd10;
    localparam logic [3:0] GB_LVT    = 4'd11;

    // width codes
    localparam logic [1:0] WIDTH_ZERO = 2'd0;
    localparam logic [1:0] WIDTH_WIDE = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CR,
        MODE_RUN,
        MODE_GEN
    } mode_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic [16:0] columns;
        logic [5:0]  break_class;
        logic        text_done;
        logic        last_of_run;
    } result_t;

    // one queue word: the clusters closed by one character
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    // queue status towards the back end
    typedef struct packed {
        logic   empty;
        entry_t head;
    } q_status_t;

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ColMax}) ? ColMax : s[16:0];
    endfunction

    function automatic logic [1:0] cols_of(input logic [1:0] w);
        logic [1:0] c;
        if (w == WIDTH_WIDE)
            c = 2'd2;
        else if (w == WIDTH_ZERO)
            c = 2'd0;
        else
            c = 2'd1;
        return c;
    endfunction

    function automatic logic hangul_joins(input logic [3:0] prev, input logic [3:0] nxt);
        logic j;
        if (prev == GB_L)
            j = nxt inside {GB_L, GB_V, GB_LV, GB_LVT};
        else if (prev == GB_LV || prev == GB_V)
            j = nxt inside {GB_V, GB_T};
        else if (prev == GB_LVT || prev == GB_T)
            j = (nxt == GB_T);
        else
            j = 1'b0;
        return j;
    endfunction

    function automatic result_t make_result(
        input logic [15:0] start,
        input logic [15:0] length,
        input logic [16:0] base_cols,
        input logic [16:0] prep_cols,
        input logic [16:0] ext_cols,
        input logic [5:0]  head_lb,
        input logic [3:0]  head_gb,
        input logic        head_th,
        input logic        thai_on,
        input logic        done
    );
        result_t r;
        logic [5:0] cls;
        cls = head_lb;
        if (head_lb == LB_SA && !(thai_on && head_th))
            cls = (head_gb inside {GB_EXT, GB_SPMARK}) ? LB_CM : LB_AL;
        r.start       = start;
        r.length      = length;
        r.columns     = sat_add(sat_add(base_cols, prep_cols), ext_cols);
        r.break_class = cls;
        r.text_done   = done;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/gcs_front.sv @@
// Front end: accepts characters, runs the cluster state and pushes closed clusters.
// Depends on gcs_pkg.
`default_nettype none

module gcs_front #(
    parameter int unsigned MAX_TEXT_LEN = gcs_pkg::MaxTextLen
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [5:0]         lb_class,
    input  wire logic [1:0]         width_class,
    input  wire logic [3:0]         gb_class,
    input  wire logic               is_thai,
    input  wire logic               end_of_text,
    input  wire logic               thai_support,
    output gcs_pkg::entry_t         push_entry,
    output logic                    push
);
    import gcs_pkg::*;

    localparam int unsigned LenCapInt = (MAX_TEXT_LEN < 65535) ? MAX_TEXT_LEN : 65535;
    localparam logic [15:0] LenCap    = LenCapInt[15:0];

    mode_t       mode_reg, mode_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] len_reg, len_next;
    logic [5:0]  hlb_reg, hlb_next;
    logic [3:0]  hgb_reg, hgb_next;
    logic        hth_reg, hth_next;
    logic [3:0]  prev_reg, prev_next;
    logic [16:0] base_reg, base_next;
    logic [16:0] prep_reg, prep_next;
    logic [16:0] ext_reg, ext_next;

    result_t     res_s [2];
    logic [1:0]  n_res;
    logic        joined;
    logic [16:0] col;

    assign col = {15'd0, cols_of(width_class)};

    // next state, with the clusters closed along the way
    always_comb
    begin
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        len_next   = len_reg;
        hlb_next   = hlb_reg;
        hgb_next   = hgb_reg;
        hth_next   = hth_reg;
        prev_next  = prev_reg;
        base_next  = base_reg;
        prep_next  = prep_reg;
        ext_next   = ext_reg;
        res_s[0]   = '0;
        res_s[1]   = '0;
        n_res      = 2'd0;
        joined     = 1'b0;

        if (mode_reg != MODE_IDLE && len_reg < LenCap)
        begin
            case (mode_reg)
                MODE_CR:
                begin
                    if (gb_class == GB_LF)
                    begin
                        len_next = len_reg + 16'd1;
                        joined   = 1'b1;
                        res_s[n_res[0]] = make_result(start_next, len_next, base_next,
                            prep_next, ext_next, hlb_next, hgb_next, hth_next,
                            thai_support, end_of_text);
                        n_res     = n_res + 2'd1;
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                    end
                end
                MODE_RUN:
                begin
                    if (lb_class == hlb_reg)
                    begin
                        len_next  = len_reg + 16'd1;
                        base_next = sat_add(base_reg, col);
                        joined    = 1'b1;
                    end
                end
                default:
                begin
                    if (!(gb_class inside {GB_CTRL, GB_CR, GB_LF}))
                    begin
                        if (hangul_joins(prev_reg, gb_class))
                        begin
                            base_next = 17'd2;
                            prev_next = gb_class;
                            joined    = 1'b1;
                        end
                        else if (gb_class inside {GB_EXT, GB_SPMARK})
                        begin
                            ext_next = sat_add(ext_reg, col);
                            joined   = 1'b1;
                        end
                        else if (prev_reg == GB_PRE)
                        begin
                            hlb_next  = lb_class;
                            hgb_next  = gb_class;
                            hth_next  = is_thai;
                            prep_next = sat_add(prep_reg, base_reg);
                            base_next = col;
                            prev_next = gb_class;
                            joined    = 1'b1;
                        end
                        if (joined)
                            len_next = len_reg + 16'd1;
                    end
                end
            endcase
        end

        if (!joined)
        begin
            // close the open cluster and start a new one on this character
            if (mode_next != MODE_IDLE)
            begin
                res_s[n_res[0]] = make_result(start_next, len_next, base_next,
                    prep_next, ext_next, hlb_next, hgb_next, hth_next,
                    thai_support, 1'b0);
                n_res     = n_res + 2'd1;
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            start_next = idx_reg;
            len_next   = 16'd1;
            hlb_next   = lb_class;
            hgb_next   = gb_class;
            hth_next   = is_thai;
            prev_next  = gb_class;
            base_next  = col;
            prep_next  = '0;
            ext_next   = '0;
            if (lb_class == LB_BK || lb_class == LB_NL || gb_class == GB_LF)
            begin
                res_s[n_res[0]] = make_result(start_next, len_next, base_next,
                    prep_next, ext_next, hlb_next, hgb_next, hth_next,
                    thai_support, end_of_text);
                n_res     = n_res + 2'd1;
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            else if (gb_class == GB_CR)
                mode_next = MODE_CR;
            else if (lb_class inside {LB_SP, LB_ZW, LB_WJ})
                mode_next = MODE_RUN;
            else if (gb_class == GB_CTRL)
            begin
                // a control character outside a space run stands alone
                res_s[n_res[0]] = make_result(start_next, len_next, base_next,
                    prep_next, ext_next, hlb_next, hgb_next, hth_next,
                    thai_support, end_of_text);
                n_res     = n_res + 2'd1;
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            else
                mode_next = MODE_GEN;
        end

        idx_next = idx_reg + 16'd1;

        if (end_of_text)
        begin
            // flush whatever is still open and restart the index
            if (mode_next != MODE_IDLE)
            begin
                res_s[n_res[0]] = make_result(start_next, len_next, base_next,
                    prep_next, ext_next, hlb_next, hgb_next, hth_next,
                    thai_support, 1'b1);
                n_res     = n_res + 2'd1;
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            idx_next = '0;
        end
    end

    // queue word for this character
    always_comb
    begin
        push_entry.first  = res_s[0];
        push_entry.second = res_s[1];
        push_entry.two    = (n_res == 2'd2);
        push_entry.first.last_of_run  = (n_res == 2'd1);
        push_entry.second.last_of_run = (n_res == 2'd2);
        push = accept && (n_res != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            idx_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            hlb_reg   <= '0;
            hgb_reg   <= '0;
            hth_reg   <= 1'b0;
            prev_reg  <= '0;
            base_reg  <= '0;
            prep_reg  <= '0;
            ext_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            hlb_reg   <= hlb_next;
            hgb_reg   <= hgb_next;
            hth_reg   <= hth_next;
            prev_reg  <= prev_next;
            base_reg  <= base_next;
            prep_reg  <= prep_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

`default_nettype wire

@@ src/gcs_queue.sv @@
// Short queue of cluster words between the front and back ends.
// Depends on gcs_pkg.
`default_nettype none

module gcs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire gcs_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output gcs_pkg::q_status_t   status
);
    import gcs_pkg::*;

    entry_t             entries [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg;
    logic [QPtrW-1:0]   rd_ptr_reg;
    logic [QPtrW:0]     count_reg, count_next;

    localparam logic [QPtrW:0] CountFull = QPtrW'(QDepth - 1) + (QPtrW + 1)'(1);

    assign full         = (count_reg == CountFull);
    assign status.empty = (count_reg == '0);
    assign status.head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPtrW + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPtrW + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/gcs_back.sv @@
// Back end: unpacks queue words into single clusters and holds the output register.
// Depends on gcs_pkg.
`default_nettype none

module gcs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gcs_pkg::q_status_t status,
    output logic                    pop,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output gcs_pkg::result_t        out_res
);
    import gcs_pkg::*;

    logic    valid_reg;
    logic    sel_reg, sel_next;
    result_t res_reg;
    logic    load;
    logic    take;

    assign load = !valid_reg || !out_stall;
    assign take = load && !status.empty;

    // advance to the second cluster of a word, or drop the word once drained
    always_comb
    begin
        sel_next = sel_reg;
        pop      = 1'b0;
        if (take)
        begin
            if (status.head.two && !sel_reg)
                sel_next = 1'b1;
            else
            begin
                sel_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= !status.empty;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= sel_reg ? status.head.second : status.head.first;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ src/grapheme_cluster_segmenter.sv @@
// Top level of the grapheme cluster segmenter: front end, word queue, back end.
// Depends on gcs_pkg, gcs_front, gcs_queue and gcs_back.
`default_nettype none

// The block takes one character per cycle while in_stall is low, as looked-up
// properties, and returns one word per grapheme cluster: start index, length,
// display columns and the resolved line break class. The front end decides
// combinationally whether a character joins the open cluster, so it sustains one
// character per clock while the queue has room; a character closes zero, one or
// two clusters. The back end delivers one cluster word per clock from its output
// register while out_stall is low; the four-word queue absorbs the second word of
// a character that closes two clusters. A closed cluster passes through the queue
// and the output register. Clusters are only reported once closed: a run stays
// open until a character that does not join it arrives or end_of_text flushes it.
// thai_support is taken from cfg_write_data while cfg_write_en is high and
// must only change while the block is idle.
module grapheme_cluster_segmenter #(
    parameter int unsigned MAX_TEXT_LEN = gcs_pkg::MaxTextLen
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_write_data,
    // character channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  lb_class,
    input  wire logic [1:0]  width_class,
    input  wire logic [3:0]  gb_class,
    input  wire logic        is_thai,
    input  wire logic        end_of_text,
    // cluster channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      cluster_start,
    output logic [15:0]      cluster_length,
    output logic [16:0]      cluster_columns,
    output logic [5:0]       cluster_break_class,
    output logic             text_done,
    output logic             last_of_run
);
    import gcs_pkg::*;

    logic      thai_support_reg;
    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    entry_t    push_entry;
    q_status_t status;
    result_t   out_res;

    // hold the Thai option between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thai_support_reg <= 1'b0;
        else if (cfg_write_en)
            thai_support_reg <= cfg_write_data;
    end

    // stall the character side only when the queue has no room
    assign in_stall = full;
    assign accept   = in_valid && !full;

    gcs_front #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .lb_class     (lb_class),
        .width_class  (width_class),
        .gb_class     (gb_class),
        .is_thai      (is_thai),
        .end_of_text  (end_of_text),
        .thai_support (thai_support_reg),
        .push_entry   (push_entry),
        .push         (push)
    );

    gcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .status     (status)
    );

    gcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign cluster_start       = out_res.start;
    assign cluster_length      = out_res.length;
    assign cluster_columns     = out_res.columns;
    assign cluster_break_class = out_res.break_class;
    assign text_done           = out_res.text_done;
    assign last_of_run         = out_res.last_of_run;

endmodule

`default_nettype wire

@@ tb/gcs_cluster_book_pkg.sv @@
// Cluster bookkeeping for the grapheme cluster segmenter test: character record type and a
// class that predicts the cluster words of each accepted character and checks the DUT's.
// Depends on gcs_pkg for class codes, the mode enum and the result word layout.

package gcs_cluster_book_pkg;

    import gcs_pkg::*;

    // one character as the block sees it
    typedef struct packed {
        logic [5:0] lb;
        logic [1:0] width;
        logic [3:0] gb;
        logic       thai;
        logic       eot;
    } char_props_t;

    localparam int unsigned LenCap =
        (gcs_pkg::MaxTextLen < 65535) ? gcs_pkg::MaxTextLen : 65535;

    class cluster_book;

        logic        thai_on;
        logic [15:0] char_idx;
        logic [15:0] open_start;
        logic [15:0] open_len;
        mode_t       mode;
        logic [5:0]  head_lb;
        logic [3:0]  head_gb;
        logic        head_th;
        logic [3:0]  prev_gb;
        logic [16:0] base_cols;
        logic [16:0] prep_cols;
        logic [16:0] ext_cols;

        result_t     awaited_clusters[$];
        int unsigned mismatches;

        function new();
            thai_on    = 1'b0;
            char_idx   = '0;
            open_start = '0;
            open_len   = '0;
            mode       = MODE_IDLE;
            head_lb    = '0;
            head_gb    = '0;
            head_th    = 1'b0;
            prev_gb    = '0;
            base_cols  = '0;
            prep_cols  = '0;
            ext_cols   = '0;
            mismatches = 0;
        endfunction

        function void set_thai(logic v);
            thai_on = v;
        endfunction

        function int unsigned awaited_count();
            return awaited_clusters.size();
        endfunction

        // clamp a column sum at the top of the column range
        function logic [16:0] add_cols(logic [16:0] a, logic [16:0] b);
            int unsigned s;
            s = a + b;
            if (s > ColMax)
            begin
                s = ColMax;
            end
            return s[16:0];
        endfunction

        function logic hangul_follows(logic [3:0] prev, logic [3:0] nxt);
            case (prev)
                GB_L:
                    return nxt == GB_L || nxt == GB_V || nxt == GB_LV || nxt == GB_LVT;
                GB_V, GB_LV:
                    return nxt == GB_V || nxt == GB_T;
                GB_T, GB_LVT:
                    return nxt == GB_T;
                default:
                    return 1'b0;
            endcase
        endfunction

        // close the open cluster and return its word
        function result_t close_open(logic done);
            result_t r;
            logic [5:0] cls;
            if (head_lb != LB_SA || (thai_on && head_th))
            begin
                cls = head_lb;
            end
            else if (head_gb == GB_EXT || head_gb == GB_SPMARK)
            begin
                cls = LB_CM;
            end
            else
            begin
                cls = LB_AL;
            end
            r.start       = open_start;
            r.length      = open_len;
            r.columns     = add_cols(add_cols(base_cols, prep_cols), ext_cols);
            r.break_class = cls;
            r.text_done   = done;
            r.last_of_run = 1'b0;
            mode          = MODE_IDLE;
            open_len      = '0;
            return r;
        endfunction

        // advance the cluster state by one accepted character
        function void take_char(char_props_t c);
            result_t     made[$];
            result_t     r;
            logic [16:0] cols;
            logic        joined;
            if (c.width == 2'd2)
            begin
                cols = 17'd2;
            end
            else if (c.width == 2'd0)
            begin
                cols = 17'd0;
            end
            else
            begin
                cols = 17'd1;
            end
            joined = 1'b0;

            if (mode != MODE_IDLE && open_len < LenCap)
            begin
                case (mode)
                    MODE_CR:
                    begin
                        if (c.gb == GB_LF)
                        begin
                            open_len = open_len + 16'd1;
                            joined   = 1'b1;
                            made.push_back(close_open(c.eot));
                        end
                    end
                    MODE_RUN:
                    begin
                        if (c.lb == head_lb)
                        begin
                            open_len  = open_len + 16'd1;
                            base_cols = add_cols(base_cols, cols);
                            joined    = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (c.gb != GB_CTRL && c.gb != GB_CR && c.gb != GB_LF)
                        begin
                            if (hangul_follows(prev_gb, c.gb))
                            begin
                                base_cols = 17'd2;
                                prev_gb   = c.gb;
                                joined    = 1'b1;
                            end
                            else if (c.gb == GB_EXT || c.gb == GB_SPMARK)
                            begin
                                ext_cols = add_cols(ext_cols, cols);
                                joined   = 1'b1;
                            end
                            else if (prev_gb == GB_PRE)
                            begin
                                head_lb   = c.lb;
                                head_gb   = c.gb;
                                head_th   = c.thai;
                                prep_cols = add_cols(prep_cols, base_cols);
                                base_cols = cols;
                                prev_gb   = c.gb;
                                joined    = 1'b1;
                            end
                            if (joined)
                            begin
                                open_len = open_len + 16'd1;
                            end
                        end
                    end
                endcase
            end

            if (!joined)
            begin
                if (mode != MODE_IDLE)
                begin
                    made.push_back(close_open(1'b0));
                end
                open_start = char_idx;
                open_len   = 16'd1;
                head_lb    = c.lb;
                head_gb    = c.gb;
                head_th    = c.thai;
                prev_gb    = c.gb;
                base_cols  = cols;
                prep_cols  = '0;
                ext_cols   = '0;
                if (c.lb == LB_BK || c.lb == LB_NL || c.gb == GB_LF)
                begin
                    made.push_back(close_open(c.eot));
                end
                else if (c.gb == GB_CR)
                begin
                    mode = MODE_CR;
                end
                else if (c.lb == LB_SP || c.lb == LB_ZW || c.lb == LB_WJ)
                begin
                    mode = MODE_RUN;
                end
                else if (c.gb == GB_CTRL)
                begin
                    made.push_back(close_open(c.eot));
                end
                else
                begin
                    mode = MODE_GEN;
                end
            end

            char_idx = char_idx + 16'd1;
            if (c.eot)
            begin
                if (mode != MODE_IDLE)
                begin
                    made.push_back(close_open(1'b1));
                end
                char_idx = '0;
            end

            if (made.size() != 0)
            begin
                r = made.pop_back();
                r.last_of_run = 1'b1;
                made.push_back(r);
            end
            foreach (made[i])
            begin
                awaited_clusters.push_back(made[i]);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // check one accepted cluster word against the oldest prediction
        function void match_cluster(result_t got);
            result_t want;
            if (awaited_clusters.size() == 0)
            begin
                $error("cluster word with none awaited: start %0d, length %0d",
                       got.start, got.length);
                mismatches++;
                return;
            end
            want = awaited_clusters.pop_front();
            compare_field("cluster_start", want.start, got.start);
            compare_field("cluster_length", want.length, got.length);
            compare_field("cluster_columns", want.columns, got.columns);
            compare_field("cluster_break_class", want.break_class, got.break_class);
            compare_field("text_done", want.text_done, got.text_done);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

    endclass

endpackage

@@ tb/grapheme_cluster_segmenter_test.sv @@
// Self-checking test of grapheme_cluster_segmenter: directed and random character strings
// under several idling patterns, with cluster words checked against a predictor.
// Depends on gcs_pkg, gcs_cluster_book_pkg and the segmenter RTL.

module grapheme_cluster_segmenter_test;

    import gcs_pkg::*;
    import gcs_cluster_book_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] WidthNarrow = 2'd1;
    localparam logic [1:0] WidthOdd    = 2'd3;
    localparam logic [3:0] GbOther     = 4'd0;
    localparam logic [3:0] GbOddLow    = 4'd12;
    localparam logic [3:0] GbOddTop    = 4'd15;
    localparam logic [5:0] LbPlain     = 6'd8;
    localparam logic [5:0] LbTop       = 6'd63;

    localparam int unsigned RunItems    = 80;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned TimeLimit   = 1000000;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [5:0]  lb_class       = '0;
    logic [1:0]  width_class    = '0;
    logic [3:0]  gb_class       = '0;
    logic        is_thai        = 1'b0;
    logic        end_of_text    = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [15:0] cluster_start;
    logic [15:0] cluster_length;
    logic [16:0] cluster_columns;
    logic [5:0]  cluster_break_class;
    logic        text_done;
    logic        last_of_run;

    // idling odds in percent, set per phase; hold_off forces a long receiver stall
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    logic        hold_off  = 1'b0;

    char_props_t script[$];
    cluster_book book;

    grapheme_cluster_segmenter dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .lb_class            (lb_class),
        .width_class         (width_class),
        .gb_class            (gb_class),
        .is_thai             (is_thai),
        .end_of_text         (end_of_text),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .cluster_start       (cluster_start),
        .cluster_length      (cluster_length),
        .cluster_columns     (cluster_columns),
        .cluster_break_class (cluster_break_class),
        .text_done           (text_done),
        .last_of_run         (last_of_run)
    );

    always #1 clk = ~clk;

    // hard stop if the block wedges or loses a word
    initial
    begin
        #TimeLimit;
        $display("Verification failed");
        $finish;
    end

    function automatic char_props_t glyph(logic [5:0] lb, logic [1:0] w, logic [3:0] gb,
                                          logic th, logic eot);
        char_props_t c;
        c.lb    = lb;
        c.width = w;
        c.gb    = gb;
        c.thai  = th;
        c.eot   = eot;
        return c;
    endfunction

    function automatic logic [1:0] any_width();
        return 2'($urandom_range(0, 3));
    endfunction

    // a line-break class for an ordinary base: SA, CM, AL or one of the others
    function automatic logic [5:0] base_lb();
        return 6'($urandom_range(LB_SA, LbTop));
    endfunction

    // mostly Other, now and then an undefined grapheme code that must act as Other
    function automatic logic [3:0] base_gb();
        return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(GbOddLow, GbOddTop)) : GbOther;
    endfunction

    function automatic void push_marks(int unsigned most, logic [5:0] lb, logic th);
        repeat ($urandom_range(0, most))
        begin
            script.push_back(glyph(lb, any_width(),
                                   $urandom_range(0, 1) ? GB_EXT : GB_SPMARK, th, 1'b0));
        end
    endfunction

    // append one well-formed cluster with random content, or one noise character
    function automatic void add_cluster();
        logic [5:0] cls;
        logic       th;
        case ($urandom_range(0, 11))
            0:
            begin
                script.push_back(glyph(base_lb(), any_width(), GB_CR, 1'b0, 1'b0));
                script.push_back(glyph(base_lb(), any_width(), GB_LF, 1'b0, 1'b0));
            end
            1:
            begin
                script.push_back(glyph(base_lb(), any_width(), GB_CR, 1'b0, 1'b0));
            end
            2:
            begin
                case ($urandom_range(0, 2))
                    0: script.push_back(glyph(LB_BK, any_width(), base_gb(), 1'b0, 1'b0));
                    1: script.push_back(glyph(LB_NL, any_width(), base_gb(), 1'b0, 1'b0));
                    default: script.push_back(glyph(base_lb(), any_width(), GB_LF, 1'b0, 1'b0));
                endcase
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0: cls = LB_SP;
                    1: cls = LB_ZW;
                    default: cls = LB_WJ;
                endcase
                repeat ($urandom_range(1, 6))
                begin
                    script.push_back(glyph(cls, any_width(), base_gb(), 1'b0, 1'b0));
                end
            end
            4:
            begin
                script.push_back(glyph(base_lb(), any_width(), GB_CTRL, 1'b0, 1'b0));
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        repeat ($urandom_range(1, 2))
                        begin
                            script.push_back(glyph(base_lb(), any_width(), GB_L, 1'b0, 1'b0));
                        end
                        repeat ($urandom_range(1, 2))
                        begin
                            script.push_back(glyph(base_lb(), any_width(), GB_V, 1'b0, 1'b0));
                        end
                    end
                    1: script.push_back(glyph(base_lb(), any_width(), GB_LV, 1'b0, 1'b0));
                    default: script.push_back(glyph(base_lb(), any_width(), GB_LVT, 1'b0, 1'b0));
                endcase
                repeat ($urandom_range(0, 2))
                begin
                    script.push_back(glyph(base_lb(), any_width(), GB_T, 1'b0, 1'b0));
                end
                push_marks(1, LB_CM, 1'b0);
            end
            6:
            begin
                script.push_back(glyph(base_lb(), any_width(), base_gb(), 1'($urandom), 1'b0));
                push_marks(3, LB_CM, 1'b0);
            end
            7:
            begin
                repeat ($urandom_range(1, 2))
                begin
                    script.push_back(glyph(base_lb(), any_width(), GB_PRE, 1'b0, 1'b0));
                end
                script.push_back(glyph(base_lb(), any_width(), base_gb(), 1'($urandom), 1'b0));
                push_marks(2, LB_CM, 1'b0);
            end
            8:
            begin
                // SA-headed cluster, Thai or not, with trailing marks of the same script
                th = 1'($urandom);
                script.push_back(glyph(LB_SA, any_width(), GbOther, th, 1'b0));
                push_marks(3, LB_SA, th);
            end
            9:
            begin
                // SA mark with no base ahead of it heads its own cluster
                script.push_back(glyph(LB_BK, WidthNarrow, GbOther, 1'b0, 1'b0));
                script.push_back(glyph(LB_SA, any_width(),
                                       $urandom_range(0, 1) ? GB_EXT : GB_SPMARK,
                                       1'($urandom), 1'b0));
                push_marks(1, LB_SA, 1'($urandom));
            end
            default:
            begin
                script.push_back(glyph(6'($urandom), 2'($urandom), 4'($urandom), 1'($urandom),
                                       $urandom_range(0, 7) == 0));
            end
        endcase
    endfunction

    // build a random text of about n characters, closed by an end-of-text character
    function automatic void compose_text(int unsigned n);
        int unsigned goal;
        char_props_t c;
        goal = script.size() + n;
        while (script.size() < goal)
        begin
            add_cluster();
            if ($urandom_range(0, 11) == 0)
            begin
                c = script.pop_back();
                c.eot = 1'b1;
                script.push_back(c);
            end
        end
        script.push_back(glyph(LB_AL, WidthNarrow, GbOther, 1'b0, 1'b1));
    endfunction

    // one of each cluster kind, the field extremes and the undefined codes
    function automatic void load_directed();
        script.push_back(glyph(LbPlain, WidthNarrow, GB_CR, 1'b0, 1'b0));
        script.push_back(glyph(LbTop, WIDTH_ZERO, GB_LF, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WidthNarrow, GB_CR, 1'b0, 1'b0));
        script.push_back(glyph(LB_BK, WIDTH_ZERO, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_NL, WidthNarrow, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_SP, WidthNarrow, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_SP, WIDTH_WIDE, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_ZW, WIDTH_ZERO, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_WJ, WIDTH_ZERO, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WidthNarrow, GB_CTRL, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WIDTH_WIDE, GB_L, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WIDTH_ZERO, GB_V, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WIDTH_ZERO, GB_T, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WIDTH_WIDE, GB_LVT, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WidthOdd, GB_T, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WIDTH_ZERO, GB_LV, 1'b0, 1'b0));
        script.push_back(glyph(LbPlain, WidthNarrow, GB_PRE, 1'b0, 1'b0));
        script.push_back(glyph(LB_AL, WIDTH_WIDE, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_CM, WIDTH_ZERO, GB_EXT, 1'b0, 1'b0));
        script.push_back(glyph(LB_CM, WidthNarrow, GB_SPMARK, 1'b0, 1'b0));
        script.push_back(glyph(LB_SA, WidthNarrow, GbOther, 1'b1, 1'b0));
        script.push_back(glyph(LB_SA, WIDTH_ZERO, GB_EXT, 1'b1, 1'b0));
        script.push_back(glyph(LB_SA, WidthNarrow, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_BK, WidthNarrow, GbOther, 1'b0, 1'b0));
        script.push_back(glyph(LB_SA, WIDTH_ZERO, GB_EXT, 1'b0, 1'b0));
        script.push_back(glyph(LbTop, WidthOdd, GbOddTop, 1'b1, 1'b0));
        script.push_back(glyph(LbPlain, WidthNarrow, GbOddLow, 1'b0, 1'b1));
    endfunction

    task automatic write_thai(input logic v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        book.set_thai(v);
    endtask

    // Offer every character of the script in turn. Valid stays high from one word to the
    // next unless a gap is drawn, so it is never dropped and raised in the same step.
    task automatic play_script();
        char_props_t c;
        while (script.size() != 0)
        begin
            c = script.pop_front();
            while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            lb_class    <= c.lb;
            width_class <= c.width;
            gb_class    <= c.gb;
            is_thai     <= c.thai;
            end_of_text <= c.eot;
            // hold the word until an edge sees it unstalled
            do
            begin
                @(posedge clk);
            end
            while (in_stall);
            book.take_char(c);
        end
        in_valid <= 1'b0;
    endtask

    // stall the cluster channel for a fixed stretch, counted here
    task automatic hold_receiver(input int unsigned cycles);
        hold_off <= 1'b1;
        repeat (cycles)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b0;
    endtask

    // wait for every predicted word, then allow for the pipeline to settle
    task automatic drain();
        while (book.awaited_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall);
        gap_pct   = gap;
        stall_pct = stall;
        play_script();
        drain();
    endtask

    // Cluster sink: sample the handshake as it stood at the edge, then draw the next stall.
    // Only one assignment to out_stall per edge.
    initial
    begin : cluster_sink
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.start       = cluster_start;
                got.length      = cluster_length;
                got.columns     = cluster_columns;
                got.break_class = cluster_break_class;
                got.text_done   = text_done;
                got.last_of_run = last_of_run;
                book.match_cluster(got);
            end
            out_stall <= hold_off || (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
        end
    end

    // Every phase ends on an end-of-text character, so no cluster is open when
    // thai_support changes between phases.
    initial
    begin : stimulus_main
        book = new();
        repeat (4)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with Thai support on, so both SA outcomes show
        write_thai(1'b1);
        load_directed();
        run_phase(0, 0);

        write_thai(1'b0);
        compose_text(RunItems);
        run_phase(0, 0);

        write_thai(1'b1);
        compose_text(RunItems);
        run_phase(87, 0);

        write_thai(1'b0);
        compose_text(RunItems);
        run_phase(0, 87);

        write_thai(1'b1);
        compose_text(RunItems);
        run_phase(32, 32);

        // back-pressure: keep offering while the receiver holds off, so the queue fills
        write_thai(1'b0);
        compose_text(RunItems);
        gap_pct   = 0;
        stall_pct = 0;
        fork
            play_script();
            hold_receiver(HoldCycles);
        join
        drain();

        if (book.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
